@@ hw/rtl/dmn_pkg.sv @@
// Shared widths, constants and a leading-one helper for the division magic number block.
package dmn_pkg;

  localparam int unsigned DivisorW   = 32;
  localparam int unsigned MagicW     = 64;
  localparam int unsigned RemW       = DivisorW;
  localparam int unsigned PosW       = $clog2(DivisorW);
  localparam int unsigned CntW       = $clog2(MagicW + DivisorW);
  localparam int unsigned NibW       = 4;
  localparam int unsigned MinDivisor = 3;

  function automatic logic [1:0] nib_lead_one(input logic [NibW-1:0] nib);
    logic [1:0] idx;
    priority if (nib[3]) idx = 2'd3;
    else if (nib[2]) idx = 2'd2;
    else if (nib[1]) idx = 2'd1;
    else idx = 2'd0;
    return idx;
  endfunction

endpackage

@@ hw/rtl/division_magic_number_top.sv @@
// Magic number for division by an invariant 32-bit divisor, bit-serial restoring divider.
// A divisor below three gives its word in the cycle after acceptance, busy stays low.
// Otherwise: leading-one scan (one nibble a cycle), then the 33-bit compare/subtract unit builds
// the quotient bit by bit, and the round-up add gives the word that is shown.
// One divisor at a time: busy_o is high from acceptance until the result word is shown.
// Reset clears the sequencer and the strobe; the receiver cannot stall a result word.
module division_magic_number_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dmn_pkg::DivisorW-1:0]  divisor_i,
  output logic                          valid_o,
  output logic [dmn_pkg::MagicW-1:0]    magic_o,
  output logic                          invalid_o
);
  import dmn_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam logic [PosW-1:0] ScanBase = PosW'(DivisorW - NibW);

  logic [1:0]          state_q, state_d;
  logic [DivisorW-1:0] d_q, d_d;
  logic [DivisorW-1:0] scan_q, scan_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [MagicW-1:0]   quo_q, quo_d;
  logic                first_q, first_d;
  logic                valid_q, valid_d;
  logic [MagicW-1:0]   magic_q, magic_d;
  logic                invalid_q, invalid_d;

  logic                accept;
  logic [RemW:0]       rem_sh;
  logic [RemW+1:0]     diff;
  logic                ge;
  logic [PosW-1:0]     lead_pos;

  assign accept   = start_i && (state_q == StIdle);
  assign rem_sh   = {rem_q, first_q};
  assign diff     = {1'b0, rem_sh} - {2'b00, d_q};
  assign ge       = !diff[RemW+1];
  assign lead_pos = pos_q + PosW'(nib_lead_one(scan_q[DivisorW-1 -: NibW]));

  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    scan_d    = scan_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    first_d   = first_q;
    valid_d   = 1'b0;
    magic_d   = magic_q;
    invalid_d = invalid_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (divisor_i < DivisorW'(MinDivisor)) begin
            valid_d   = 1'b1;
            magic_d   = '0;
            invalid_d = 1'b1;
          end else begin
            d_d     = divisor_i;
            scan_d  = divisor_i;
            pos_d   = ScanBase;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (scan_q[DivisorW-1 -: NibW] != '0) begin
          cnt_d   = CntW'(MagicW) + CntW'(lead_pos);
          rem_d   = '0;
          quo_d   = '0;
          first_d = 1'b1;
          state_d = StDiv;
        end else begin
          scan_d = scan_q << NibW;
          pos_d  = pos_q - PosW'(NibW);
        end
      end
      StDiv: begin
        first_d = 1'b0;
        quo_d   = {quo_q[MagicW-2:0], ge};
        rem_d   = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      StFin: begin
        valid_d   = 1'b1;
        magic_d   = quo_q + MagicW'(rem_q != '0);
        invalid_d = 1'b0;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    scan_q    <= scan_d;
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    first_q   <= first_d;
    magic_q   <= magic_d;
    invalid_q <= invalid_d;
  end

  assign busy_o    = (state_q != StIdle);
  assign valid_o   = valid_q;
  assign magic_o   = magic_q;
  assign invalid_o = invalid_q;

`ifndef SYNTH
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result word shown while busy");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && invalid_o) |-> (magic_o == '0)) else $error("invalid word with nonzero magic");

  a_small_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (divisor_i < DivisorW'(MinDivisor))) |=> (valid_o && invalid_o))
    else $error("small divisor not flagged next cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < d_q)) else $error("remainder not below divisor");

  a_big_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (divisor_i >= DivisorW'(MinDivisor))) |=> (busy_o && !valid_o))
    else $error("valid divisor did not start the divider");
`endif

endmodule

@@ tb/division_magic_number_top_tb.sv @@
// Self-checking testbench for the division magic number block: directed and random divisors.
module division_magic_number_top_tb;

  import dmn_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned RandomWords   = 1950;
  localparam int unsigned DrainCycles   = 150;

  class magic_ledger;
    typedef struct {
      logic [MagicW-1:0] magic;
      logic              invalid;
    } magic_word_t;

    magic_word_t pending_magic[$];
    bit          failed;

    function new();
      failed = 1'b0;
    endfunction

    function automatic logic [MagicW-1:0] magic_for(logic [DivisorW-1:0] d);
      int unsigned       lead;
      logic [MagicW-1:0] quo;
      logic [MagicW-1:0] rem;
      lead = 0;
      for (int unsigned b = 0; b < DivisorW; b++) begin
        if (d[b]) lead = b;
      end
      quo = '0;
      rem = '0;
      for (int unsigned k = 0; k <= MagicW + lead; k++) begin
        rem = {rem[MagicW-2:0], (k == 0)};
        quo = quo << 1;
        if (rem >= MagicW'(d)) begin
          rem = rem - MagicW'(d);
          quo[0] = 1'b1;
        end
      end
      return quo + MagicW'(rem != '0);
    endfunction

    function void note_divisor(logic [DivisorW-1:0] d);
      magic_word_t w;
      if (d < MinDivisor) begin
        w.magic   = '0;
        w.invalid = 1'b1;
      end else begin
        w.magic   = magic_for(d);
        w.invalid = 1'b0;
      end
      pending_magic = {pending_magic, w};
    endfunction

    function void check_word(logic [MagicW-1:0] magic, logic invalid);
      magic_word_t w;
      if (pending_magic.size() == 0) begin
        $error("unexpected word: magic %h invalid %b", magic, invalid);
        failed = 1'b1;
        return;
      end
      w = pending_magic.pop_front();
      if (magic !== w.magic) begin
        $error("magic: expected %h, actual %h", w.magic, magic);
        failed = 1'b1;
      end
      if (invalid !== w.invalid) begin
        $error("invalid: expected %b, actual %b", w.invalid, invalid);
        failed = 1'b1;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [DivisorW-1:0] divisor_i;
  logic                valid_o;
  logic [MagicW-1:0]   magic_o;
  logic                invalid_o;

  magic_ledger ledger;
  int unsigned idle_cycles;
  bit          watching;

  division_magic_number_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .divisor_i (divisor_i),
    .valid_o   (valid_o),
    .magic_o   (magic_o),
    .invalid_o (invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) ledger.check_word(magic_o, invalid_o);
      if (start_i && !busy_o) ledger.note_divisor(divisor_i);
      if (watching) begin
        if (valid_o || (start_i && !busy_o)) begin
          idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
          $display("division_magic_number_top: mismatch");
          $finish;
        end else begin
          idle_cycles <= idle_cycles + 1;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [DivisorW-1:0] pick_divisor();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return DivisorW'($urandom_range(0, MinDivisor - 1));
    if (roll < 10) return DivisorW'(1) << $urandom_range(0, DivisorW - 1);
    if (roll < 25) return $urandom;
    if (roll < 35) return $urandom >> $urandom_range(0, DivisorW - 1);
    return ($urandom >> $urandom_range(0, DivisorW - 2)) | DivisorW'(1);
  endfunction

  task automatic send_divisor(logic [DivisorW-1:0] d, int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      divisor_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    divisor_i <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  logic [DivisorW-1:0] directed_divisors[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
    32'd1021, 32'h0001_0000, 32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'hFFFF_FFFB, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_00FF
  };

  initial begin
    ledger      = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    divisor_i   = '0;
    idle_cycles = 0;
    watching    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni   <= 1'b1;
    watching <= 1'b1;
    @(posedge clk_i);

    foreach (directed_divisors[i]) begin
      send_divisor(directed_divisors[i], (i % 3 == 0) ? pick_gap() : 0);
    end
    for (int unsigned n = 0; n < RandomWords; n++) begin
      send_divisor(pick_divisor(), pick_gap());
    end
    start_i <= 1'b0;

    while (ledger.pending_magic.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (!ledger.failed && ledger.pending_magic.size() == 0) begin
      $display("division_magic_number_top: match");
    end else begin
      $display("division_magic_number_top: mismatch");
    end
    $finish;
  end

endmodule
